[src/assert_macros.svh]
// Assertion helpers used by the sequencer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/ldaseq_pkg.sv]
package ldaseq_pkg;

	// Upper byte of an address; its complement keeps a zero-page sum in page zero
	localparam logic [15:0] PAGE_HIGH_MASK = 16'hFF00;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_DATA  = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		MODE_IMM = 3'd0,
		MODE_ZP  = 3'd1,
		MODE_ZPX = 3'd2,
		MODE_ABS = 3'd3,
		MODE_ABX = 3'd4,
		MODE_ABY = 3'd5,
		MODE_IZX = 3'd6,
		MODE_IZY = 3'd7
	} mode_t;

	// Sequencer step: which byte the next data transaction brings
	typedef enum logic [2:0] {
		STEP_IDLE   = 3'd0,
		STEP_OPND   = 3'd1,
		STEP_ABS_HI = 3'd2,
		STEP_PTR_LO = 3'd3,
		STEP_DATA   = 3'd4,
		STEP_PTR_HI = 3'd5
	} step_t;

	typedef struct packed {
		cmd_t        command;
		mode_t       addr_mode;
		logic [7:0]  index_x;
		logic [7:0]  index_y;
		logic [15:0] program_counter;
		logic [7:0]  read_data;
	} ldaseq_req_t;

	typedef struct packed {
		logic [15:0] read_address;
		logic        done_res;
		logic [7:0]  accumulator;
		logic        negative_flag;
		logic        zero_flag;
		logic [15:0] next_pc;
	} ldaseq_res_t;

	typedef struct packed {
		step_t       step;
		mode_t       mode;
		logic [15:0] eff_addr;
		logic [15:0] pointer;
		logic [15:0] pc;
		logic [7:0]  x;
		logic [7:0]  y;
	} ldaseq_state_t;

endpackage

[src/ldaseq_if.sv]
// Request channel: start or returned data byte
interface ldaseq_req_if;
	logic                valid;
	logic                ready;
	ldaseq_pkg::cmd_t    command;
	ldaseq_pkg::mode_t   addr_mode;
	logic [7:0]          index_x;
	logic [7:0]          index_y;
	logic [15:0]         program_counter;
	logic [7:0]          read_data;

	modport source (
		output valid, command, addr_mode, index_x, index_y, program_counter,
			read_data,
		input  ready
	);
	modport sink (
		input  valid, command, addr_mode, index_x, index_y, program_counter,
			read_data,
		output ready
	);
endinterface

// Response channel: next read address or finished load
interface ldaseq_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_address;
	logic        done_res;
	logic [7:0]  accumulator;
	logic        negative_flag;
	logic        zero_flag;
	logic [15:0] next_pc;

	modport source (
		output valid, read_address, done_res, accumulator, negative_flag, zero_flag,
			next_pc,
		input  ready
	);
	modport sink (
		input  valid, read_address, done_res, accumulator, negative_flag, zero_flag,
			next_pc,
		output ready
	);
endinterface

[src/ldaseq_step.sv]
module ldaseq_step (
	input  ldaseq_pkg::ldaseq_state_t st,
	input  ldaseq_pkg::ldaseq_req_t   req,
	output ldaseq_pkg::ldaseq_state_t nxt,
	output ldaseq_pkg::ldaseq_res_t   res,
	output logic                      emit
);
	import ldaseq_pkg::*;

	logic [7:0]  b;
	logic [15:0] zp_sum;
	logic [15:0] zp_inc;
	logic [15:0] abs_base;
	logic [15:0] ptr_full;
	logic [7:0]  abs_idx;

	assign b = req.read_data;

	// Zero-page operand plus X, kept within page zero
	assign zp_sum   = ({8'h00, b} + {8'h00, st.x}) & ~PAGE_HIGH_MASK;
	// Next pointer byte address, wrapping in page zero
	assign zp_inc   = (st.eff_addr + 16'd1) & ~PAGE_HIGH_MASK;
	assign abs_base = st.eff_addr | ({b, 8'h00} & PAGE_HIGH_MASK);
	assign ptr_full = st.pointer | ({b, 8'h00} & PAGE_HIGH_MASK);

	always_comb begin
		unique case (st.mode)
			MODE_ABX: abs_idx = st.x;
			MODE_ABY: abs_idx = st.y;
			default:  abs_idx = 8'h00;
		endcase
	end

	// Advance the sequencer by one transaction
	always_comb begin
		nxt  = st;
		res  = '0;
		emit = 1'b0;
		if (req.command == CMD_START) begin
			nxt.mode     = req.addr_mode;
			nxt.x        = req.index_x;
			nxt.y        = req.index_y;
			nxt.pc       = req.program_counter + 16'd1;
			nxt.eff_addr = '0;
			nxt.pointer  = '0;
			nxt.step     = STEP_OPND;
			res.read_address = req.program_counter;
			emit = 1'b1;
		end else begin
			unique case (st.step)
				STEP_OPND: begin
					emit = 1'b1;
					unique case (st.mode)
						MODE_IMM: begin
							nxt.step          = STEP_IDLE;
							res.done_res      = 1'b1;
							res.accumulator   = b;
							res.negative_flag = b[7];
							res.zero_flag     = (b == 8'h00);
							res.next_pc       = st.pc;
						end
						MODE_ZP: begin
							nxt.eff_addr     = {8'h00, b};
							nxt.step         = STEP_DATA;
							res.read_address = {8'h00, b};
						end
						MODE_ZPX: begin
							nxt.eff_addr     = zp_sum;
							nxt.step         = STEP_DATA;
							res.read_address = zp_sum;
						end
						MODE_ABS, MODE_ABX, MODE_ABY: begin
							nxt.eff_addr     = {8'h00, b};
							nxt.pc           = st.pc + 16'd1;
							nxt.step         = STEP_ABS_HI;
							res.read_address = st.pc;
						end
						MODE_IZX: begin
							nxt.eff_addr     = zp_sum;
							nxt.step         = STEP_PTR_LO;
							res.read_address = zp_sum;
						end
						MODE_IZY: begin
							nxt.eff_addr     = {8'h00, b};
							nxt.step         = STEP_PTR_LO;
							res.read_address = {8'h00, b};
						end
					endcase
				end
				STEP_ABS_HI: begin
					nxt.eff_addr     = abs_base + {8'h00, abs_idx};
					nxt.step         = STEP_DATA;
					res.read_address = abs_base + {8'h00, abs_idx};
					emit = 1'b1;
				end
				STEP_PTR_LO: begin
					nxt.pointer      = {8'h00, b};
					nxt.eff_addr     = zp_inc;
					nxt.step         = STEP_PTR_HI;
					res.read_address = zp_inc;
					emit = 1'b1;
				end
				STEP_PTR_HI: begin
					nxt.pointer = ptr_full;
					if (st.mode == MODE_IZY) begin
						nxt.eff_addr     = ptr_full + {8'h00, st.y};
						res.read_address = ptr_full + {8'h00, st.y};
					end else begin
						nxt.eff_addr     = ptr_full;
						res.read_address = ptr_full;
					end
					nxt.step = STEP_DATA;
					emit = 1'b1;
				end
				STEP_DATA: begin
					nxt.step          = STEP_IDLE;
					res.done_res      = 1'b1;
					res.accumulator   = b;
					res.negative_flag = b[7];
					res.zero_flag     = (b == 8'h00);
					res.next_pc       = st.pc;
					emit = 1'b1;
				end
				// Data with no read outstanding: drop it
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

endmodule

[src/load_accumulator_address_sequencer.sv]
// Channel  Dir  Transaction
// req      in   start (mode, X, Y, PC) or data byte returned for the last read
// rsp      out  next read address, or finished load with A, N, Z and next PC
//
// One request transaction per cycle while rsp is not stalled; its response is registered and shows in the next cycle.
// The response passes through a single response register; the step logic sits in front of it.
// Reset clears the sequencer to idle and drops any pending response.
// A stalled response blocks req only while it is still held; taking it frees req at once.
// Data arriving while idle is taken and produces no response.
`include "assert_macros.svh"

module load_accumulator_address_sequencer (
	input  logic         clk,
	input  logic         arst_n,
	ldaseq_req_if.sink   req,
	ldaseq_rsp_if.source rsp
);
	import ldaseq_pkg::*;

	ldaseq_state_t st_q;
	ldaseq_state_t st_nxt;
	ldaseq_req_t   req_pl;
	ldaseq_res_t   res_nxt;
	ldaseq_res_t   res_q;
	logic          emit;
	logic          valid_q;
	logic          req_fire;

	assign req_pl = '{
		command:         req.command,
		addr_mode:       req.addr_mode,
		index_x:         req.index_x,
		index_y:         req.index_y,
		program_counter: req.program_counter,
		read_data:       req.read_data
	};

	assign req.ready = !valid_q || rsp.ready;
	assign req_fire  = req.valid && req.ready;

	ldaseq_step u_step (
		.st   (st_q),
		.req  (req_pl),
		.nxt  (st_nxt),
		.res  (res_nxt),
		.emit (emit)
	);

	// Advance sequencer state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{step: STEP_IDLE, mode: MODE_IMM, default: '0};
		end else if (req_fire) begin
			st_q <= st_nxt;
		end
	end

	// Hold the response until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (req_fire) begin
			valid_q <= emit;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire && emit) begin
			res_q <= res_nxt;
		end
	end

	assign rsp.valid         = valid_q;
	assign rsp.read_address  = res_q.read_address;
	assign rsp.done_res      = res_q.done_res;
	assign rsp.accumulator   = res_q.accumulator;
	assign rsp.negative_flag = res_q.negative_flag;
	assign rsp.zero_flag     = res_q.zero_flag;
	assign rsp.next_pc       = res_q.next_pc;

	`ASSERT_IMPL(a_no_overwrite, clk, arst_n, valid_q && !rsp.ready, !req.ready, "response overwritten while stalled")
	`ASSERT_NEXT(a_start_opnd, clk, arst_n, req_fire && req.command == CMD_START, st_q.step == STEP_OPND && valid_q, "start did not arm operand fetch")
	`ASSERT_NEXT(a_idle_drop, clk, arst_n, req_fire && req.command == CMD_DATA && st_q.step == STEP_IDLE, st_q.step == STEP_IDLE && !valid_q, "idle data produced a response")
	`ASSERT_CLK(a_done_clean, clk, arst_n, !(valid_q && rsp.done_res) || rsp.read_address == 16'h0000, "finished load carries an address")

endmodule

[bench/tb_load_accumulator_address_sequencer.sv]
module tb_load_accumulator_address_sequencer;
	import ldaseq_pkg::*;

	localparam int HOLD_CYCLES = 60;
	localparam int CYCLE_LIMIT = 100000;
	localparam int RANDOM_ITEMS = 400;
	localparam int PRESSURE_AT = 120;
	localparam int QUIET_AT = 340;
	localparam int PRINT_CAP = 20;

	// Track sequencer state and queue the response each transaction should produce
	class lda_scoreboard;
		step_t       step;
		mode_t       mode;
		logic [15:0] eff_addr;
		logic [15:0] pointer;
		logic [15:0] pc;
		logic [7:0]  x;
		logic [7:0]  y;
		ldaseq_res_t pending[$];
		int          errors;
		int          requests_seen;
		int          requests_ignored;
		int          results_checked;
		int          loads_done;
		bit [7:0]    modes_loaded;

		function new();
			step = STEP_IDLE;
			mode = MODE_IMM;
			eff_addr = '0;
			pointer = '0;
			pc = '0;
			x = '0;
			y = '0;
		endfunction

		// Close the load: value, N and Z flags, PC past the operands
		function ldaseq_res_t load_result(logic [7:0] b);
			ldaseq_res_t r;
			r = '0;
			r.done_res = 1'b1;
			r.accumulator = b;
			r.negative_flag = b[7];
			r.zero_flag = (b == 8'h00);
			r.next_pc = pc;
			step = STEP_IDLE;
			loads_done++;
			modes_loaded[mode] = 1'b1;
			return r;
		endfunction

		function void note_request(ldaseq_req_t it);
			ldaseq_res_t r;
			logic [7:0]  b;
			logic [7:0]  low;
			r = '0;
			b = it.read_data;
			requests_seen++;
			// Start aborts anything in progress and reads the first operand byte
			if (it.command == CMD_START) begin
				mode = it.addr_mode;
				x = it.index_x;
				y = it.index_y;
				pc = it.program_counter + 16'd1;
				eff_addr = '0;
				pointer = '0;
				step = STEP_OPND;
				r.read_address = it.program_counter;
				pending.push_back(r);
				return;
			end
			case (step)
				STEP_OPND: begin
					case (mode)
						MODE_IMM: r = load_result(b);
						MODE_ZP: begin
							eff_addr = {8'h00, b};
							step = STEP_DATA;
							r.read_address = eff_addr;
						end
						MODE_ZPX: begin
							low = b + x;
							eff_addr = {8'h00, low};
							step = STEP_DATA;
							r.read_address = eff_addr;
						end
						MODE_IZX: begin
							low = b + x;
							eff_addr = {8'h00, low};
							step = STEP_PTR_LO;
							r.read_address = eff_addr;
						end
						MODE_IZY: begin
							eff_addr = {8'h00, b};
							step = STEP_PTR_LO;
							r.read_address = eff_addr;
						end
						default: begin
							// Absolute modes: fetch the high byte next
							eff_addr = {8'h00, b};
							r.read_address = pc;
							pc = pc + 16'd1;
							step = STEP_ABS_HI;
						end
					endcase
				end
				STEP_ABS_HI: begin
					eff_addr = {b, eff_addr[7:0]};
					if (mode == MODE_ABX)
						eff_addr = eff_addr + {8'h00, x};
					else if (mode == MODE_ABY)
						eff_addr = eff_addr + {8'h00, y};
					step = STEP_DATA;
					r.read_address = eff_addr;
				end
				STEP_PTR_LO: begin
					// Address of the pointer high byte stays in page zero
					pointer = {8'h00, b};
					low = eff_addr[7:0] + 8'd1;
					eff_addr = {8'h00, low};
					step = STEP_PTR_HI;
					r.read_address = eff_addr;
				end
				STEP_PTR_HI: begin
					pointer = {b, pointer[7:0]};
					eff_addr = pointer;
					if (mode == MODE_IZY)
						eff_addr = eff_addr + {8'h00, y};
					step = STEP_DATA;
					r.read_address = eff_addr;
				end
				STEP_DATA: r = load_result(b);
				default: begin
					// Data while idle is dropped silently
					requests_ignored++;
					return;
				end
			endcase
			pending.push_back(r);
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= PRINT_CAP)
				$display("ERROR: %s", what);
		endtask

		task compare_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report_mismatch($sformatf("response %0d %s: got %h, expected %h",
					results_checked, name, got, want));
		endtask

		task check_response(ldaseq_res_t got);
			ldaseq_res_t want;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("response with none outstanding: addr %h done %b",
					got.read_address, got.done_res));
				return;
			end
			want = pending.pop_front();
			results_checked++;
			compare_field("read_address", got.read_address, want.read_address);
			compare_field("done_res", 16'(got.done_res), 16'(want.done_res));
			compare_field("accumulator", 16'(got.accumulator), 16'(want.accumulator));
			compare_field("negative_flag", 16'(got.negative_flag), 16'(want.negative_flag));
			compare_field("zero_flag", 16'(got.zero_flag), 16'(want.zero_flag));
			compare_field("next_pc", got.next_pc, want.next_pc);
		endtask
	endclass

	logic clk;
	logic arst_n;
	ldaseq_req_if req_ch();
	ldaseq_rsp_if rsp_ch();

	lda_scoreboard sb = new();

	bit quiet;
	bit sender_calm;
	bit receiver_calm;
	bit hold_request;
	int tick_total;

	load_accumulator_address_sequencer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Abort a hung run
	always @(posedge clk) begin
		tick_total++;
		if (tick_total == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d responses outstanding", tick_total,
				sb.pending.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// Check responses before noting the request taken on the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response('{rsp_ch.read_address, rsp_ch.done_res, rsp_ch.accumulator,
					rsp_ch.negative_flag, rsp_ch.zero_flag, rsp_ch.next_pc});
			if (req_ch.valid && req_ch.ready)
				sb.note_request('{req_ch.command, req_ch.addr_mode, req_ch.index_x,
					req_ch.index_y, req_ch.program_counter, req_ch.read_data});
		end
	end

	// Response side: random stall bursts, calm stretches, one long hold-off
	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 31) == 0)
				receiver_calm = !receiver_calm;
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else if (!quiet && !receiver_calm && $urandom_range(0, 4) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 8) - 1) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Favor boundary bytes a quarter of the time
	function automatic logic [7:0] pick_byte();
		logic [7:0] corners[5] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
		if ($urandom_range(0, 3) == 0)
			return corners[$urandom_range(0, 4)];
		return 8'($urandom_range(0, 255));
	endfunction

	// Offer one transaction, optionally after an idle burst, and hold until taken
	task automatic send_item(input ldaseq_req_t it);
		int gap;
		gap = 0;
		if (!quiet && !sender_calm && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 8);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= it.command;
		req_ch.addr_mode <= it.addr_mode;
		req_ch.index_x <= it.index_x;
		req_ch.index_y <= it.index_y;
		req_ch.program_counter <= it.program_counter;
		req_ch.read_data <= it.read_data;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic send_start(input mode_t m, input logic [7:0] xv, input logic [7:0] yv,
		input logic [15:0] pcv);
		send_item('{CMD_START, m, xv, yv, pcv, 8'($urandom_range(0, 255))});
	endtask

	// Unused fields carry random values on data transactions
	task automatic send_data(input logic [7:0] b);
		send_item('{CMD_DATA, mode_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), b});
	endtask

	initial begin
		int         real_sent;
		int         kind;
		int         n_data;
		int         full_len;
		bit         gen_idle;
		bit         pressure_done;
		mode_t      m;
		logic [15:0] pcv;

		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.command <= CMD_START;
		req_ch.addr_mode <= MODE_IMM;
		req_ch.index_x <= '0;
		req_ch.index_y <= '0;
		req_ch.program_counter <= '0;
		req_ch.read_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle data, flags, PC wrap, zero-page wraps, abort, 16-bit index wrap
		send_data(8'h5A);
		send_start(MODE_IMM, 8'h00, 8'hFF, 16'hFFFF);
		send_data(8'h00);
		send_start(MODE_ZP, 8'hFF, 8'h00, 16'h0000);
		send_data(8'hFF);
		send_data(8'h80);
		send_start(MODE_ZPX, 8'hFF, 8'h00, 16'h8000);
		send_data(8'h02);
		send_data(8'h7F);
		send_start(MODE_ABS, 8'h12, 8'h34, 16'h7FFF);
		send_data(8'h34);
		send_start(MODE_ABX, 8'hFF, 8'h01, 16'hFFFF);
		send_data(8'hFF);
		send_data(8'hFF);
		send_data(8'h01);
		send_start(MODE_ABY, 8'h01, 8'h80, 16'h1234);
		send_data(8'h80);
		send_data(8'h12);
		send_data(8'hFE);
		send_start(MODE_IZX, 8'h80, 8'h00, 16'h00FF);
		send_data(8'h7F);
		send_data(8'h00);
		send_data(8'h40);
		send_data(8'hC3);
		send_start(MODE_IZY, 8'h00, 8'hFF, 16'h4000);
		send_data(8'hFF);
		send_data(8'hFF);
		send_data(8'hFF);
		send_data(8'h01);

		// Random: mostly complete loads, some aborted ones and stray data
		real_sent = 0;
		gen_idle = 1'b1;
		pressure_done = 1'b0;
		while (real_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 15) == 0)
				sender_calm = !sender_calm;
			if (!pressure_done && real_sent >= PRESSURE_AT) begin
				pressure_done = 1'b1;
				hold_request = 1'b1;
			end
			if (real_sent >= QUIET_AT)
				quiet = 1'b1;
			kind = $urandom_range(0, 19);
			if (kind == 0) begin
				send_data(pick_byte());
				if (!gen_idle)
					real_sent++;
			end else begin
				m = mode_t'($urandom_range(0, 7));
				if ($urandom_range(0, 7) == 0)
					pcv = 16'hFFFD + 16'($urandom_range(0, 2));
				else
					pcv = 16'($urandom_range(0, 65535));
				case (m)
					MODE_IMM: full_len = 1;
					MODE_ZP, MODE_ZPX: full_len = 2;
					default: full_len = 3;
				endcase
				n_data = (kind <= 2) ? $urandom_range(0, full_len - 1) : full_len;
				send_start(m, pick_byte(), pick_byte(), pcv);
				repeat (n_data) send_data(pick_byte());
				real_sent += 1 + n_data;
				gen_idle = (n_data == full_len);
			end
		end
		req_ch.valid <= 1'b0;

		// Drain outstanding responses before the summary
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run covered %0d request transactions (%0d ignored while idle), %0d responses",
			sb.requests_seen, sb.requests_ignored, sb.results_checked);
		$display("Finished loads: %0d; modes completed (bit per mode): %b",
			sb.loads_done, sb.modes_loaded);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/ldaseq_pkg.sv
src/ldaseq_if.sv
src/ldaseq_step.sv
src/load_accumulator_address_sequencer.sv
bench/tb_load_accumulator_address_sequencer.sv
